[rtl/lcdw_pkg.sv]
// Shared types, command codes and the init instruction table for the LCD bus writer.
`default_nettype none

package lcdw_pkg;

    // Command codes carried in the cmd field of an input word.
    localparam logic [2:0] CMD_INSTR  = 3'd0;
    localparam logic [2:0] CMD_DATA   = 3'd1;
    localparam logic [2:0] CMD_INIT   = 3'd2;
    localparam logic [2:0] CMD_CURSOR = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FOUR_BIT_MODE  = 2'd0;
    localparam logic [1:0] CFG_PULSE_MS       = 2'd1;
    localparam logic [1:0] CFG_POWER_UP_MS    = 2'd2;
    localparam logic [1:0] CFG_CLEAR_EXTRA_MS = 2'd3;

    // Controller instructions.
    localparam logic [7:0] INS_FUNC_8  = 8'h38;
    localparam logic [7:0] INS_FUNC_4  = 8'h28;
    localparam logic [7:0] INS_HOME    = 8'h02;
    localparam logic [7:0] INS_DISP_ON = 8'h0C;
    localparam logic [7:0] INS_CLEAR   = 8'h01;
    localparam logic [7:0] INS_ENTRY   = 8'h06;
    localparam logic [7:0] INS_DDRAM   = 8'h80;
    localparam logic [7:0] ROW1_OFFSET = 8'h40;

    // Reset values of the configuration registers.
    localparam logic       FOUR_BIT_RESET    = 1'b1;
    localparam logic [7:0] PULSE_RESET       = 8'd1;
    localparam logic [9:0] POWER_UP_RESET    = 10'd50;
    localparam logic [7:0] CLEAR_EXTRA_RESET = 8'd1;

    // Last step index of the init sequence (step 0 is the power-up wait).
    localparam logic [2:0] INIT_LAST_STEP_4 = 3'd5;
    localparam logic [2:0] INIT_LAST_STEP_8 = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] value;
        logic [1:0] line;
        logic [5:0] cell_req;
    } lcdw_cmd_t;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [7:0] data_pins;
        logic [9:0] hold_ms;
        logic       last;
    } lcdw_setting_t;

    typedef struct packed {
        logic       four_bit_mode;
        logic [7:0] pulse_ms;
        logic [9:0] power_up_ms;
        logic [7:0] clear_extra_ms;
    } lcdw_cfg_t;

    // One unit of work for the back end: a power-up wait or one byte write.
    typedef struct packed {
        logic       is_wait;
        logic       rs;
        logic [7:0] byte_val;
        logic       extra;
        logic       last;
    } lcdw_job_t;

    localparam int JOB_W     = $bits(lcdw_job_t);
    localparam int SETTING_W = $bits(lcdw_setting_t);

    // Instruction sent at a given init step (steps 1 and up).
    function automatic logic [7:0] init_byte(input logic four, input logic [2:0] step);
        logic [7:0] b;
        b = INS_ENTRY;
        if (four) begin
            case (step)
                3'd1:    b = INS_HOME;
                3'd2:    b = INS_FUNC_4;
                3'd3:    b = INS_DISP_ON;
                3'd4:    b = INS_CLEAR;
                default: b = INS_ENTRY;
            endcase
        end else begin
            case (step)
                3'd1:    b = INS_FUNC_8;
                3'd2:    b = INS_DISP_ON;
                3'd3:    b = INS_CLEAR;
                default: b = INS_ENTRY;
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[rtl/char_lcd_bus_writer.sv]
// Top level of the character LCD bus writer: config registers, front end, back end, queues.
`default_nettype none

// Turns host commands (instruction, data, init, set cursor, clear) into a stream of
// pin settings for an HD44780-style character LCD: RS, EN, D7..D0 and the time in
// milliseconds each setting is held. Commands enter through a queue-style port
// (push/full) and settings leave through another (empty/pop). A byte takes four
// settings in 4-bit mode (two nibbles, each EN high then EN low) and two in 8-bit
// mode; init takes 21 settings in 4-bit mode and 9 in 8-bit mode, and a set-cursor
// to a row above one or an unknown command produces nothing. The back end emits
// one setting per clock while a job is waiting and the result queue has room;
// that back-end rate sets the throughput. A new command is taken as soon as the
// front end hands its last job to the job queue, so commands flow back to back.
// The first setting of a command reaches the result port through the front end's
// command registers, the job queue and the result queue. Configuration
// is written through cfg_valid/cfg_index/cfg_data (always ready) and must only
// change while the block is idle. JOB_DEPTH and OUT_DEPTH size the internal job
// queue and the result queue (2 to 16 words each).
module char_lcd_bus_writer #(
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire lcdw_pkg::lcdw_cmd_t     command,
    output logic                         full,
    output logic                         empty,
    input  wire logic                    pop,
    output lcdw_pkg::lcdw_setting_t      setting,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [9:0]              cfg_data
);

    lcdw_pkg::lcdw_cfg_t     cfg_reg, cfg_next;
    lcdw_pkg::lcdw_job_t     front_job, back_job;
    lcdw_pkg::lcdw_setting_t back_setting;
    logic                    job_push, job_full, job_empty, job_pop;
    logic                    set_push, set_full;
    logic [lcdw_pkg::JOB_W-1:0]     job_rd_data;
    logic [lcdw_pkg::SETTING_W-1:0] set_rd_data;

    // Configuration writes are always taken; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lcdw_pkg::CFG_FOUR_BIT_MODE:  cfg_next.four_bit_mode  = cfg_data[0];
                lcdw_pkg::CFG_PULSE_MS:       cfg_next.pulse_ms       = cfg_data[7:0];
                lcdw_pkg::CFG_POWER_UP_MS:    cfg_next.power_up_ms    = cfg_data;
                lcdw_pkg::CFG_CLEAR_EXTRA_MS: cfg_next.clear_extra_ms = cfg_data[7:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.four_bit_mode  <= lcdw_pkg::FOUR_BIT_RESET;
            cfg_reg.pulse_ms       <= lcdw_pkg::PULSE_RESET;
            cfg_reg.power_up_ms    <= lcdw_pkg::POWER_UP_RESET;
            cfg_reg.clear_extra_ms <= lcdw_pkg::CLEAR_EXTRA_RESET;
        end else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end classifies commands and expands init into its instruction list.
    lcdw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .command       (command),
        .full          (full),
        .four_bit_mode (cfg_reg.four_bit_mode),
        .job_push      (job_push),
        .job           (front_job),
        .job_full      (job_full)
    );

    // The job queue decouples command handling from pin sequencing.
    lcdw_fifo #(
        .WIDTH (lcdw_pkg::JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (front_job),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_rd_data),
        .empty   (job_empty)
    );

    assign back_job = lcdw_pkg::lcdw_job_t'(job_rd_data);

    // The back end tracks the RS and data levels last driven and emits settings.
    lcdw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (back_job),
        .job_empty (job_empty),
        .job_pop   (job_pop),
        .set_push  (set_push),
        .setting   (back_setting),
        .set_full  (set_full)
    );

    // The result queue holds finished settings until the consumer pops them.
    lcdw_fifo #(
        .WIDTH (lcdw_pkg::SETTING_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (set_push),
        .wr_data (back_setting),
        .full    (set_full),
        .rd_en   (pop),
        .rd_data (set_rd_data),
        .empty   (empty)
    );

    assign setting = lcdw_pkg::lcdw_setting_t'(set_rd_data);

endmodule

`default_nettype wire

[rtl/lcdw_fifo.sv]
// Small register FIFO used between the front end, the back end and the result port.
`default_nettype none

module lcdw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/lcdw_front.sv]
// Front end: accepts commands, drops ignored ones and breaks each into jobs.
`default_nettype none

module lcdw_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire lcdw_pkg::lcdw_cmd_t command,
    output logic                    full,
    input  wire logic               four_bit_mode,
    output logic                    job_push,
    output lcdw_pkg::lcdw_job_t     job,
    input  wire logic               job_full
);

    logic            busy_reg, busy_next;
    logic            is_init_reg, is_init_next;
    logic            rs_reg, rs_next;
    logic [7:0]      byte_reg, byte_next;
    logic [2:0]      step_reg, step_next;
    logic            accept, cmd_ok, job_done;
    logic [7:0]      init_val;
    logic [7:0]      cursor_val;

    assign init_val   = lcdw_pkg::init_byte(four_bit_mode, step_reg);
    assign cursor_val = lcdw_pkg::INS_DDRAM
                        | ((command.line == 2'd1) ? lcdw_pkg::ROW1_OFFSET : 8'h00)
                        | {2'b00, command.cell_req};

    always_comb
    begin
        job = '0;
        if (is_init_reg)
        begin
            if (step_reg == 3'd0)
            begin
                job.is_wait = 1'b1;
            end else
            begin
                job.byte_val = init_val;
                job.extra    = (init_val == lcdw_pkg::INS_CLEAR);
                job.last     = four_bit_mode ? (step_reg == lcdw_pkg::INIT_LAST_STEP_4)
                                             : (step_reg == lcdw_pkg::INIT_LAST_STEP_8);
            end
        end else
        begin
            job.rs       = rs_reg;
            job.byte_val = byte_reg;
            job.last     = 1'b1;
        end
    end

    assign job_push = busy_reg && !job_full;
    assign job_done = job_push && job.last;
    assign full     = busy_reg && !job_done;
    assign accept   = push && !full;

    // Set cursor to a row above one and unknown codes produce no work.
    always_comb
    begin
        case (command.cmd)
            lcdw_pkg::CMD_INSTR,
            lcdw_pkg::CMD_DATA,
            lcdw_pkg::CMD_INIT,
            lcdw_pkg::CMD_CLEAR:  cmd_ok = 1'b1;
            lcdw_pkg::CMD_CURSOR: cmd_ok = (command.line[1] == 1'b0);
            default:              cmd_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next    = busy_reg;
        is_init_next = is_init_reg;
        rs_next      = rs_reg;
        byte_next    = byte_reg;
        step_next    = step_reg;
        if (job_push)
        begin
            step_next = step_reg + 1'b1;
            if (job.last)
            begin
                busy_next = 1'b0;
            end
        end
        if (accept && cmd_ok)
        begin
            busy_next    = 1'b1;
            step_next    = 3'd0;
            is_init_next = (command.cmd == lcdw_pkg::CMD_INIT);
            rs_next      = (command.cmd == lcdw_pkg::CMD_DATA);
            case (command.cmd)
                lcdw_pkg::CMD_CURSOR: byte_next = cursor_val;
                lcdw_pkg::CMD_CLEAR:  byte_next = lcdw_pkg::INS_CLEAR;
                default:              byte_next = command.value;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            is_init_reg <= 1'b0;
            step_reg    <= 3'd0;
        end else
        begin
            busy_reg    <= busy_next;
            is_init_reg <= is_init_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rs_reg   <= rs_next;
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire

[rtl/lcdw_back.sv]
// Back end: jobs become EN high/low pin settings, one per cycle unless stalled.
`default_nettype none

module lcdw_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lcdw_pkg::lcdw_cfg_t cfg,
    input  wire lcdw_pkg::lcdw_job_t job,
    input  wire logic                job_empty,
    output logic                     job_pop,
    output logic                     set_push,
    output lcdw_pkg::lcdw_setting_t  setting,
    input  wire logic                set_full
);

    logic [1:0] phase_reg, phase_next;
    logic       rs_level_reg, rs_level_next;
    logic [7:0] data_level_reg, data_level_next;
    logic       final_phase;
    logic [7:0] strobe_pins;
    logic [9:0] low_hold;

    assign set_push = !job_empty && !set_full;
    assign job_pop  = set_push && final_phase;

    always_comb
    begin
        if (!cfg.four_bit_mode)
        begin
            strobe_pins = job.byte_val;
        end else if (phase_reg[1])
        begin
            strobe_pins = {job.byte_val[3:0], data_level_reg[3:0]};
        end else
        begin
            strobe_pins = {job.byte_val[7:4], data_level_reg[3:0]};
        end
    end

    always_comb
    begin
        final_phase = job.is_wait ? 1'b1
                    : (cfg.four_bit_mode ? (phase_reg == 2'd3) : (phase_reg == 2'd1));
        low_hold = {2'b00, cfg.pulse_ms};
        if (final_phase && job.extra)
        begin
            low_hold = 10'({1'b0, cfg.pulse_ms} + {1'b0, cfg.clear_extra_ms});
        end
        setting      = '0;
        setting.last = job.last && final_phase;
        if (job.is_wait)
        begin
            setting.rs        = rs_level_reg;
            setting.en        = 1'b0;
            setting.data_pins = data_level_reg;
            setting.hold_ms   = cfg.power_up_ms;
        end else if (!phase_reg[0])
        begin
            setting.rs        = job.rs;
            setting.en        = 1'b1;
            setting.data_pins = strobe_pins;
            setting.hold_ms   = {2'b00, cfg.pulse_ms};
        end else
        begin
            setting.rs        = job.rs;
            setting.en        = 1'b0;
            setting.data_pins = data_level_reg;
            setting.hold_ms   = low_hold;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        rs_level_next   = rs_level_reg;
        data_level_next = data_level_reg;
        if (set_push)
        begin
            phase_next = final_phase ? 2'd0 : phase_reg + 1'b1;
            if (!job.is_wait && !phase_reg[0])
            begin
                rs_level_next   = job.rs;
                data_level_next = strobe_pins;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 2'd0;
            rs_level_reg   <= 1'b0;
            data_level_reg <= 8'd0;
        end else
        begin
            phase_reg      <= phase_next;
            rs_level_reg   <= rs_level_next;
            data_level_reg <= data_level_next;
        end
    end

endmodule

`default_nettype wire

[rtl/lcdw_checker.sv]
// Port-level checks for the LCD bus writer and the bind that attaches them.
`default_nettype none

module lcdw_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    empty,
    input wire logic                    pop,
    input wire lcdw_pkg::lcdw_setting_t setting
);

    // Reset leaves no settings waiting.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty during reset");

    // An EN high phase is always followed by an EN low phase, so it never ends a run.
    a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && setting.en) |-> !setting.last)
        else $error("EN high setting marked last");

    // EN high phases hold for pulse_ms, which fits in eight bits.
    a_high_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && setting.en) |-> (setting.hold_ms[9:8] == 2'b00))
        else $error("EN high hold too long");

    // A waiting word that is not popped stays put.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(setting)))
        else $error("waiting word changed or vanished");

endmodule

bind char_lcd_bus_writer lcdw_checker u_lcdw_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .empty   (empty),
    .pop     (pop),
    .setting (setting)
);

`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the character LCD bus writer: directed table, then random words.
`timescale 1ns / 1ps

module tb_top;

    // Codes above CMD_CLEAR are not commands; the block must drop them silently.
    localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
    localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;

    // The watchdog gives up after this many cycles with no accepted word on any port.
    // The longest quiet stretch in a correct run is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles to let a command that makes no settings clear the pipeline before a
    // register write.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_PHASES = 6;
    localparam int WORDS_PER_PHASE = 60;

    // One row of the directed table: either a register write or a command word.
    // Rows with has_typed set carry their whole expected run, written by hand.
    typedef struct packed {
        logic                                is_reg;
        logic [1:0]                          reg_index;
        logic [9:0]                          reg_data;
        lcdw_pkg::lcdw_cmd_t                 word;
        logic                                has_typed;
        logic [2:0]                          n_typed;
        lcdw_pkg::lcdw_setting_t [3:0]       typed_run;
    } stim_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    push;
    lcdw_pkg::lcdw_cmd_t     command;
    logic                    full;
    logic                    empty;
    logic                    pop;
    lcdw_pkg::lcdw_setting_t setting;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [1:0]              cfg_index;
    logic [9:0]              cfg_data;

    char_lcd_bus_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .command   (command),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .setting   (setting),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running 2 ns clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pin settings still owed by the block, oldest first.
    lcdw_pkg::lcdw_setting_t expected_settings[$];
    // Run computed for the command most recently accepted.
    lcdw_pkg::lcdw_setting_t run_q[$];
    stim_row_t               stim_table[$];

    int unsigned   mismatch_count;
    // calm switches off random idling on both sides; hold_off_req asks the
    // receiver for one long stall so the block backs up into its input.
    bit            calm;
    bit            hold_off_req;

    // Shadow copy of the configuration registers.
    logic          cur_four_bit;
    logic [7:0]    cur_pulse;
    logic [9:0]    cur_power_up;
    logic [7:0]    cur_clear_extra;
    // Levels last driven on RS and D7..D0.
    logic          lvl_rs;
    logic [7:0]    lvl_data;

    function automatic lcdw_pkg::lcdw_setting_t pin_setting(input logic rs, input logic en,
                                                            input logic [7:0] pins,
                                                            input logic [9:0] hold,
                                                            input logic last);
        lcdw_pkg::lcdw_setting_t s;
        s.rs        = rs;
        s.en        = en;
        s.data_pins = pins;
        s.hold_ms   = hold;
        s.last      = last;
        return s;
    endfunction

    function automatic lcdw_pkg::lcdw_cmd_t cmd_word(input logic [2:0] cmd,
                                                     input logic [7:0] value,
                                                     input logic [1:0] line,
                                                     input logic [5:0] col);
        lcdw_pkg::lcdw_cmd_t w;
        w.cmd      = cmd;
        w.value    = value;
        w.line     = line;
        w.cell_req = col;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Predictor. Every byte is an EN-high phase and an EN-low phase per
    // nibble (4-bit mode) or per byte (8-bit mode). The EN-low phase of
    // the final nibble may carry extra hold (clear during init).
    // ------------------------------------------------------------------
    task automatic strobe_pins(input logic [7:0] pins, input logic [7:0] low_extra);
        lvl_data = pins;
        run_q.push_back(pin_setting(lvl_rs, 1'b1, lvl_data, 10'(cur_pulse), 1'b0));
        run_q.push_back(pin_setting(lvl_rs, 1'b0, lvl_data,
                                    10'(cur_pulse) + 10'(low_extra), 1'b0));
    endtask

    task automatic send_lcd_byte(input logic rs, input logic [7:0] b,
                                 input logic [7:0] low_extra);
        lvl_rs = rs;
        if (cur_four_bit)
        begin
            // D3..D0 are not driven in 4-bit mode and keep their old levels.
            strobe_pins({b[7:4], lvl_data[3:0]}, 8'd0);
            strobe_pins({b[3:0], lvl_data[3:0]}, low_extra);
        end
        else
        begin
            strobe_pins(b, low_extra);
        end
    endtask

    task automatic predict_run(input lcdw_pkg::lcdw_cmd_t w);
        lcdw_pkg::lcdw_setting_t tail;
        run_q.delete();
        case (w.cmd)
            lcdw_pkg::CMD_INSTR:  send_lcd_byte(1'b0, w.value, 8'd0);
            lcdw_pkg::CMD_DATA:   send_lcd_byte(1'b1, w.value, 8'd0);
            lcdw_pkg::CMD_INIT:
            begin
                // Power-up wait holds the current levels with EN low.
                run_q.push_back(pin_setting(lvl_rs, 1'b0, lvl_data, cur_power_up, 1'b0));
                if (cur_four_bit)
                begin
                    send_lcd_byte(1'b0, lcdw_pkg::INS_HOME, 8'd0);
                    send_lcd_byte(1'b0, lcdw_pkg::INS_FUNC_4, 8'd0);
                end
                else
                begin
                    send_lcd_byte(1'b0, lcdw_pkg::INS_FUNC_8, 8'd0);
                end
                send_lcd_byte(1'b0, lcdw_pkg::INS_DISP_ON, 8'd0);
                send_lcd_byte(1'b0, lcdw_pkg::INS_CLEAR, cur_clear_extra);
                send_lcd_byte(1'b0, lcdw_pkg::INS_ENTRY, 8'd0);
            end
            lcdw_pkg::CMD_CURSOR:
            begin
                // Rows two and three produce nothing at all.
                if (w.line == 2'd0)
                    send_lcd_byte(1'b0, lcdw_pkg::INS_DDRAM | {2'b00, w.cell_req}, 8'd0);
                else if (w.line == 2'd1)
                    send_lcd_byte(1'b0, lcdw_pkg::INS_DDRAM | lcdw_pkg::ROW1_OFFSET
                                        | {2'b00, w.cell_req}, 8'd0);
            end
            lcdw_pkg::CMD_CLEAR:  send_lcd_byte(1'b0, lcdw_pkg::INS_CLEAR, 8'd0);
            default:    ;
        endcase
        if (run_q.size() > 0)
        begin
            tail = run_q.pop_back();
            tail.last = 1'b1;
            run_q.push_back(tail);
        end
    endtask

    task automatic apply_reg(input logic [1:0] idx, input logic [9:0] data);
        case (idx)
            lcdw_pkg::CFG_FOUR_BIT_MODE:  cur_four_bit    = data[0];
            lcdw_pkg::CFG_PULSE_MS:       cur_pulse       = data[7:0];
            lcdw_pkg::CFG_POWER_UP_MS:    cur_power_up    = data;
            lcdw_pkg::CFG_CLEAR_EXTRA_MS: cur_clear_extra = data[7:0];
            default:            ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    task automatic add_reg(input logic [1:0] idx, input logic [9:0] data);
        stim_row_t r;
        r = '0;
        r.is_reg    = 1'b1;
        r.reg_index = idx;
        r.reg_data  = data;
        stim_table.push_back(r);
    endtask

    task automatic add_word(input lcdw_pkg::lcdw_cmd_t w);
        stim_row_t r;
        r = '0;
        r.word = w;
        stim_table.push_back(r);
    endtask

    task automatic add_typed(input lcdw_pkg::lcdw_cmd_t w, input int n,
                             input lcdw_pkg::lcdw_setting_t s0,
                             input lcdw_pkg::lcdw_setting_t s1,
                             input lcdw_pkg::lcdw_setting_t s2,
                             input lcdw_pkg::lcdw_setting_t s3);
        stim_row_t r;
        r = '0;
        r.word      = w;
        r.has_typed = 1'b1;
        r.n_typed   = 3'(n);
        r.typed_run = {s3, s2, s1, s0};
        stim_table.push_back(r);
    endtask

    // Registers only change once the block has drained: no settings owed, and
    // a short settle for any command still in flight that makes none. The
    // command port is released first so no word is offered meanwhile.
    task automatic write_reg(input logic [1:0] idx, input logic [9:0] data);
        @(negedge clk);
        push <= 1'b0;
        while (expected_settings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Offers one command word until the block takes it, then books its run.
    // A typed row replaces the predicted run, though the predictor still runs
    // so its pin levels stay in step with the block.
    task automatic send_word(input lcdw_pkg::lcdw_cmd_t w, input logic has_typed,
                             input int n_typed,
                             input lcdw_pkg::lcdw_setting_t [3:0] typed_run,
                             output bit produced);
        bit accepted;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            if (!calm && $urandom_range(99, 0) < 13)
            begin
                push <= 1'b0;
            end
            else
            begin
                command <= w;
                push    <= 1'b1;
            end
            @(posedge clk);
            if (push && !full)
                accepted = 1'b1;
        end
        predict_run(w);
        produced = (run_q.size() > 0);
        if (has_typed)
        begin
            for (int i = 0; i < n_typed; i++)
                expected_settings.push_back(typed_run[i]);
        end
        else
        begin
            foreach (run_q[i])
                expected_settings.push_back(run_q[i]);
        end
    endtask

    // Mostly real commands with random content; a set-cursor usually targets a
    // valid row, and a few words are unknown codes.
    function automatic lcdw_pkg::lcdw_cmd_t random_word();
        lcdw_pkg::lcdw_cmd_t w;
        int unsigned pick;
        pick       = $urandom_range(99, 0);
        w.value    = 8'($urandom_range(255, 0));
        w.cell_req = 6'($urandom_range(63, 0));
        w.line     = 2'($urandom_range(3, 0));
        if (pick < 25)
            w.cmd = lcdw_pkg::CMD_INSTR;
        else if (pick < 55)
            w.cmd = lcdw_pkg::CMD_DATA;
        else if (pick < 75)
        begin
            w.cmd  = lcdw_pkg::CMD_CURSOR;
            w.line = ($urandom_range(9, 0) < 8) ? 2'($urandom_range(1, 0))
                                                : 2'($urandom_range(3, 2));
        end
        else if (pick < 83)
            w.cmd = lcdw_pkg::CMD_INIT;
        else if (pick < 95)
            w.cmd = lcdw_pkg::CMD_CLEAR;
        else
            w.cmd = 3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO));
        return w;
    endfunction

    // Main sequence: reset, directed table, random phases, drain, verdict.
    initial
    begin
        stim_row_t r;
        bit        produced;
        int        phase_words;
        int        random_words;

        rst_n        = 1'b0;
        push         = 1'b0;
        command      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        hold_off_req = 1'b0;
        mismatch_count = 0;
        random_words = 0;

        cur_four_bit    = lcdw_pkg::FOUR_BIT_RESET;
        cur_pulse       = lcdw_pkg::PULSE_RESET;
        cur_power_up    = lcdw_pkg::POWER_UP_RESET;
        cur_clear_extra = lcdw_pkg::CLEAR_EXTRA_RESET;
        lvl_rs          = 1'b0;
        lvl_data        = 8'd0;

        // Directed table. Right after reset the block is in 4-bit mode with
        // one-millisecond pulses and all pins low, so the first run is plain.
        add_typed(cmd_word(lcdw_pkg::CMD_INSTR, 8'hA5, 2'd0, 6'd0), 4,
                  pin_setting(1'b0, 1'b1, 8'hA0, 10'd1, 1'b0),
                  pin_setting(1'b0, 1'b0, 8'hA0, 10'd1, 1'b0),
                  pin_setting(1'b0, 1'b1, 8'h50, 10'd1, 1'b0),
                  pin_setting(1'b0, 1'b0, 8'h50, 10'd1, 1'b1));
        // Unknown codes and set-cursor to rows two and three make nothing.
        add_typed(cmd_word(CMD_UNKNOWN_LO, 8'hFF, 2'd3, 6'd63), 0, '0, '0, '0, '0);
        add_typed(cmd_word(CMD_UNKNOWN_HI, 8'h00, 2'd0, 6'd0), 0, '0, '0, '0, '0);
        add_typed(cmd_word(lcdw_pkg::CMD_CURSOR, 8'h00, 2'd2, 6'd63), 0, '0, '0, '0, '0);
        add_typed(cmd_word(lcdw_pkg::CMD_CURSOR, 8'hFF, 2'd3, 6'd0), 0, '0, '0, '0, '0);
        add_word(cmd_word(lcdw_pkg::CMD_DATA, 8'hFF, 2'd0, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_CLEAR, 8'h00, 2'd0, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_CURSOR, 8'h00, 2'd0, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_CURSOR, 8'h00, 2'd1, 6'd63));
        add_word(cmd_word(lcdw_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0));
        // 8-bit mode with every timing register at its top value.
        add_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'd0);
        add_reg(lcdw_pkg::CFG_PULSE_MS, 10'd255);
        add_reg(lcdw_pkg::CFG_POWER_UP_MS, 10'd1023);
        add_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS, 10'd255);
        add_typed(cmd_word(lcdw_pkg::CMD_INSTR, 8'h00, 2'd0, 6'd0), 2,
                  pin_setting(1'b0, 1'b1, 8'h00, 10'd255, 1'b0),
                  pin_setting(1'b0, 1'b0, 8'h00, 10'd255, 1'b1), '0, '0);
        add_typed(cmd_word(lcdw_pkg::CMD_DATA, 8'hFF, 2'd0, 6'd0), 2,
                  pin_setting(1'b1, 1'b1, 8'hFF, 10'd255, 1'b0),
                  pin_setting(1'b1, 1'b0, 8'hFF, 10'd255, 1'b1), '0, '0);
        add_word(cmd_word(lcdw_pkg::CMD_CURSOR, 8'h00, 2'd1, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0));
        // Back to 4-bit mode: D3..D0 keep what 8-bit mode left on them.
        add_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'd1);
        add_word(cmd_word(lcdw_pkg::CMD_DATA, 8'h3C, 2'd0, 6'd0));
        // Zero pulse and power-up times still produce every setting.
        add_reg(lcdw_pkg::CFG_PULSE_MS, 10'd0);
        add_reg(lcdw_pkg::CFG_POWER_UP_MS, 10'd0);
        add_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS, 10'd0);
        add_word(cmd_word(lcdw_pkg::CMD_INIT, 8'h00, 2'd0, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_CLEAR, 8'h00, 2'd0, 6'd0));
        add_word(cmd_word(lcdw_pkg::CMD_INSTR, 8'h5A, 2'd0, 6'd0));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (stim_table[i])
        begin
            r = stim_table[i];
            if (r.is_reg)
                write_reg(r.reg_index, r.reg_data);
            else
                send_word(r.word, r.has_typed, int'(r.n_typed), r.typed_run, produced);
        end

        // Random phases, each under its own register setting: reset values,
        // the top values, zero times, then random register contents.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'(lcdw_pkg::FOUR_BIT_RESET));
                    write_reg(lcdw_pkg::CFG_PULSE_MS, 10'(lcdw_pkg::PULSE_RESET));
                    write_reg(lcdw_pkg::CFG_POWER_UP_MS, lcdw_pkg::POWER_UP_RESET);
                    write_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS,
                              10'(lcdw_pkg::CLEAR_EXTRA_RESET));
                end
                1:
                begin
                    write_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'd0);
                    write_reg(lcdw_pkg::CFG_PULSE_MS, 10'd255);
                    write_reg(lcdw_pkg::CFG_POWER_UP_MS, 10'd1023);
                    write_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS, 10'd255);
                end
                2:
                begin
                    write_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'd1);
                    write_reg(lcdw_pkg::CFG_PULSE_MS, 10'd0);
                    write_reg(lcdw_pkg::CFG_POWER_UP_MS, 10'd0);
                    write_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS, 10'd0);
                end
                default:
                begin
                    write_reg(lcdw_pkg::CFG_FOUR_BIT_MODE, 10'($urandom_range(1023, 0)));
                    write_reg(lcdw_pkg::CFG_PULSE_MS, 10'($urandom_range(1023, 0)));
                    write_reg(lcdw_pkg::CFG_POWER_UP_MS, 10'($urandom_range(1023, 0)));
                    write_reg(lcdw_pkg::CFG_CLEAR_EXTRA_MS, 10'($urandom_range(1023, 0)));
                end
            endcase
            // One phase runs with no idling on either side.
            calm = (p == 3);
            phase_words = 0;
            while (phase_words < WORDS_PER_PHASE)
            begin
                // Early on, stall the receiver for a long stretch while words keep coming.
                if (random_words == 40)
                    hold_off_req = 1'b1;
                send_word(random_word(), 1'b0, 0, '0, produced);
                if (produced)
                begin
                    phase_words++;
                    random_words++;
                end
            end
        end
        calm = 1'b0;

        @(negedge clk);
        push <= 1'b0;

        while (expected_settings.size() != 0)
            @(posedge clk);
        // Give a stray setting time to show up after the last expected one.
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("PASS char_lcd_bus_writer");
        else
            $display("FAIL char_lcd_bus_writer");
        $finish;
    end

    // Receiver: pops at random, and on request holds pop low for a long stretch.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            else
            begin
                pop <= calm || ($urandom_range(99, 0) >= 13);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // Checker: every popped setting is compared with the oldest one owed.
    always @(posedge clk)
    begin
        lcdw_pkg::lcdw_setting_t want;
        if (rst_n && pop && !empty)
        begin
            if (expected_settings.size() == 0)
            begin
                $error("setting word popped with none expected: %h", setting);
                mismatch_count++;
            end
            else
            begin
                want = expected_settings.pop_front();
                check_field("rs", want.rs, setting.rs);
                check_field("en", want.en, setting.en);
                check_field("data_pins", want.data_pins, setting.data_pins);
                check_field("hold_ms", want.hold_ms, setting.hold_ms);
                check_field("last", want.last, setting.last);
            end
        end
    end

    // Watchdog: counts cycles in which no port accepts a word.
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("FAIL char_lcd_bus_writer");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

[files.f]
rtl/lcdw_pkg.sv
rtl/lcdw_fifo.sv
rtl/lcdw_front.sv
rtl/lcdw_back.sv
rtl/char_lcd_bus_writer.sv
rtl/lcdw_checker.sv
test/tb_top.sv
